// ----- hw/rtl/prqs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Priority ready-queue scheduler package
// Operation codes, error codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package prqs_pkg;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_SCHEDULE = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK         = 2'd0,
      ERR_EMPTY      = 2'd1,
      ERR_QUEUED     = 2'd2,
      ERR_NOT_QUEUED = 2'd3
   } err_type;

   typedef struct packed {
      logic capture;
      logic issue;
      logic fetch;
      logic apply;
      logic link;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic op_insert;
      logic op_remove;
      logic stop_early;
      logic out_free;
   } status_type;

endpackage : prqs_pkg
`default_nettype wire

// ----- hw/rtl/prqs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module prqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : prqs_ram
`default_nettype wire

// ----- hw/rtl/prqs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences each operation through read issue, second fetch (remove only),
// update (skipped when rejected), link (insert only) and result transfer.
// ----------------------------------------------------------------------------
module prqs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire prqs_pkg::status_type status,
   output prqs_pkg::cmd_type         cmd
);
   import prqs_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ISSUE = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_APPLY = 6'b001000,
      ST_LINK  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.stop_early) begin
               state_in = ST_DONE;
            end else if (status.op_remove) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_APPLY;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = status.op_insert ? ST_LINK : ST_DONE;
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule : prqs_ctrl
`default_nettype wire

// ----- hw/rtl/prqs_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler datapath
// Ready bitmap, queued flags, current-thread registers, the link memories
// and the result register.
// ----------------------------------------------------------------------------
module prqs_datapath #(
   parameter int PRIORITIES = 32,
   parameter int THREADS    = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire prqs_pkg::cmd_type    cmd,
   output prqs_pkg::status_type      status,
   input  wire logic [1:0]           req_op,
   input  wire logic [4:0]           req_thread_id,
   input  wire logic [4:0]           req_priority_req,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_switched,
   output logic [4:0]                rsp_prev_thread,
   output logic                      rsp_from_valid,
   output logic [4:0]                rsp_run_thread,
   output logic [4:0]                rsp_top_priority,
   output logic [31:0]               rsp_ready_bits,
   output logic [1:0]                rsp_error_code
);
   import prqs_pkg::*;

   localparam int PW = $clog2(PRIORITIES);
   localparam int TW = $clog2(THREADS);

   // Latched request.
   op_type          op_ff;
   logic [TW-1:0]   t_ff;
   logic            tid_ok_ff;
   logic [PW-1:0]   p_ins_ff;

   // Scheduler state.
   logic [PRIORITIES-1:0] mask_ff, mask_in;
   logic [THREADS-1:0]    queued_ff, queued_in;
   logic [TW-1:0]         cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [PW-1:0]         cur_prio_ff, cur_prio_in;

   // Per-item result fields.
   logic            sw_ff, sw_in;
   logic [TW-1:0]   from_t_ff, from_t_in;
   logic            from_v_ff, from_v_in;
   err_type         err_ff, err_in;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   logic            o_sw_ff;
   logic [4:0]      o_from_ff;
   logic            o_from_v_ff;
   logic [4:0]      o_to_ff;
   logic [4:0]      o_prio_ff;
   logic [31:0]     o_bits_ff;
   err_type         o_err_ff;

   // Memory ports.
   logic            head_we, tail_we, next_we, prev_we, prio_we;
   logic [PW-1:0]   head_wa, tail_wa, head_ra, tail_ra;
   logic [TW-1:0]   head_wd, tail_wd, head_rd, tail_rd;
   logic [TW-1:0]   next_wa, next_wd, next_rd;
   logic [TW-1:0]   prev_wa, prev_wd, prev_rd;
   logic [PW-1:0]   prio_wd, prio_rd;

   logic [PW-1:0]   enc_p;
   logic            queued_t;
   logic            bit_set;
   logic            rm_h, rm_t, rm_only;
   logic            stop_early;
   logic            out_free;

   always_comb begin
      enc_p = '0;
      for (int i = PRIORITIES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            enc_p = PW'(i);
         end
      end
   end

   assign queued_t = tid_ok_ff && queued_ff[t_ff];
   assign bit_set  = mask_ff[p_ins_ff];
   assign rm_h     = (head_rd == t_ff);
   assign rm_t     = (tail_rd == t_ff);
   assign rm_only  = rm_h && rm_t;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (op_ff)
         OP_INSERT:   stop_early = !tid_ok_ff || queued_t;
         OP_REMOVE:   stop_early = !tid_ok_ff || !queued_t;
         OP_SCHEDULE: stop_early = (mask_ff == '0);
         OP_NOP:      stop_early = 1'b1;
         default:     stop_early = 1'b1;
      endcase
   end

   assign status.op_insert  = (op_ff == OP_INSERT);
   assign status.op_remove  = (op_ff == OP_REMOVE);
   assign status.stop_early = stop_early;
   assign status.out_free   = out_free;

   assign head_ra = cmd.fetch ? prio_rd : enc_p;
   assign tail_ra = cmd.fetch ? prio_rd : p_ins_ff;

   always_comb begin
      head_we = 1'b0;
      head_wa = p_ins_ff;
      head_wd = t_ff;
      tail_we = 1'b0;
      tail_wa = p_ins_ff;
      tail_wd = t_ff;
      next_we = 1'b0;
      next_wa = t_ff;
      next_wd = t_ff;
      prev_we = 1'b0;
      prev_wa = t_ff;
      prev_wd = t_ff;
      prio_we = 1'b0;
      prio_wd = p_ins_ff;
      mask_in   = mask_ff;
      queued_in = queued_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      cur_prio_in  = cur_prio_ff;
      sw_in     = sw_ff;
      from_t_in = from_t_ff;
      from_v_in = from_v_ff;
      err_in    = err_ff;

      if (cmd.issue) begin
         sw_in     = 1'b0;
         from_t_in = '0;
         from_v_in = 1'b0;
         err_in    = ERR_OK;
         if (stop_early) begin
            unique case (op_ff)
               OP_INSERT:   err_in = tid_ok_ff ? ERR_QUEUED : ERR_NOT_QUEUED;
               OP_REMOVE:   err_in = ERR_NOT_QUEUED;
               OP_SCHEDULE: err_in = ERR_EMPTY;
               OP_NOP:      err_in = ERR_OK;
               default:     err_in = ERR_OK;
            endcase
         end
      end

      if (cmd.apply) begin
         unique case (op_ff)
            OP_INSERT: begin
               if (bit_set) begin
                  next_we = 1'b1;
                  next_wa = tail_rd;
                  next_wd = t_ff;
                  prev_wd = tail_rd;
               end else begin
                  head_we = 1'b1;
                  prev_wd = t_ff;
               end
               prev_we = 1'b1;
               prev_wa = t_ff;
               tail_we = 1'b1;
               prio_we = 1'b1;
               mask_in[p_ins_ff] = 1'b1;
               queued_in[t_ff]   = 1'b1;
            end
            OP_REMOVE: begin
               head_wa = prio_rd;
               tail_wa = prio_rd;
               if (rm_only) begin
                  mask_in[prio_rd] = 1'b0;
               end else begin
                  if (rm_h) begin
                     head_we = 1'b1;
                     head_wd = next_rd;
                  end else begin
                     next_we = 1'b1;
                     next_wa = prev_rd;
                     next_wd = rm_t ? prev_rd : next_rd;
                  end
                  if (rm_t) begin
                     tail_we = 1'b1;
                     tail_wd = prev_rd;
                  end else begin
                     prev_we = 1'b1;
                     prev_wa = next_rd;
                     prev_wd = rm_h ? next_rd : prev_rd;
                  end
               end
               queued_in[t_ff] = 1'b0;
            end
            OP_SCHEDULE: begin
               if (!cur_valid_ff || head_rd != cur_ff) begin
                  sw_in        = 1'b1;
                  from_t_in    = cur_valid_ff ? cur_ff : '0;
                  from_v_in    = cur_valid_ff;
                  cur_in       = head_rd;
                  cur_valid_in = 1'b1;
                  cur_prio_in  = enc_p;
               end
            end
            OP_NOP: begin
            end
            default: begin
            end
         endcase
      end

      if (cmd.link) begin
         next_we = 1'b1;
         next_wa = t_ff;
         next_wd = t_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= op_type'(req_op);
         t_ff      <= TW'(req_thread_id);
         tid_ok_ff <= (32'(req_thread_id) < 32'(THREADS));
         p_ins_ff  <= (32'(req_priority_req) >= 32'(PRIORITIES)) ?
                      PW'(PRIORITIES - 1) : PW'(req_priority_req);
      end
      sw_ff     <= sw_in;
      from_t_ff <= from_t_in;
      from_v_ff <= from_v_in;
      err_ff    <= err_in;
      if (cmd.finish) begin
         o_sw_ff     <= sw_ff;
         o_from_ff   <= 5'(from_t_ff);
         o_from_v_ff <= from_v_ff;
         o_to_ff     <= cur_valid_ff ? 5'(cur_ff) : 5'd0;
         o_prio_ff   <= 5'(cur_prio_ff);
         o_bits_ff   <= 32'(mask_ff);
         o_err_ff    <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         queued_ff    <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         cur_prio_ff  <= PW'(PRIORITIES - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         queued_ff    <= queued_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         cur_prio_ff  <= cur_prio_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   prqs_ram #(.WIDTH(TW), .DEPTH(PRIORITIES)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_wa),
      .wr_data (head_wd),
      .rd_addr (head_ra),
      .rd_data (head_rd)
   );

   prqs_ram #(.WIDTH(TW), .DEPTH(PRIORITIES)) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_we),
      .wr_addr (tail_wa),
      .wr_data (tail_wd),
      .rd_addr (tail_ra),
      .rd_data (tail_rd)
   );

   prqs_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (t_ff),
      .rd_data (next_rd)
   );

   prqs_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (t_ff),
      .rd_data (prev_rd)
   );

   prqs_ram #(.WIDTH(PW), .DEPTH(THREADS)) u_prio_ram (
      .clock   (clock),
      .wr_en   (prio_we),
      .wr_addr (t_ff),
      .wr_data (prio_wd),
      .rd_addr (t_ff),
      .rd_data (prio_rd)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_switched     = o_sw_ff;
   assign rsp_prev_thread  = o_from_ff;
   assign rsp_from_valid   = o_from_v_ff;
   assign rsp_run_thread   = o_to_ff;
   assign rsp_top_priority = o_prio_ff;
   assign rsp_ready_bits   = o_bits_ff;
   assign rsp_error_code   = o_err_ff;

endmodule : prqs_datapath
`default_nettype wire

// ----- hw/rtl/priority_ready_queue_scheduler.sv -----
`default_nettype none
// Insert runs issue, apply, link and done; remove runs issue, fetch, apply
// and done; schedule runs issue, apply and done; rejected operations and
// no-ops go from issue to done. A new request is taken only when idle; the
// registered link memory reads and single write ports set these steps.
// Reset clears the ready bitmap, the queued flags and the current thread;
// the link memories need no clearing before requests are taken.
// ----------------------------------------------------------------------------
// Priority ready-queue scheduler
// Per-priority FIFO ready queues kept as linked lists over thread slots, with
// a bitmap of non-empty priorities used to pick the most urgent thread.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler #(
   parameter int PRIORITIES = 32,
   parameter int THREADS    = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [4:0]  req_thread_id,
   input  wire logic [4:0]  req_priority_req,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_switched,
   output logic [4:0]       rsp_prev_thread,
   output logic             rsp_from_valid,
   output logic [4:0]       rsp_run_thread,
   output logic [4:0]       rsp_top_priority,
   output logic [31:0]      rsp_ready_bits,
   output logic [1:0]       rsp_error_code
);
   import prqs_pkg::*;

   cmd_type    cmd;
   status_type status;

   prqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   prqs_datapath #(
      .PRIORITIES (PRIORITIES),
      .THREADS    (THREADS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_thread_id    (req_thread_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_switched     (rsp_switched),
      .rsp_prev_thread  (rsp_prev_thread),
      .rsp_from_valid   (rsp_from_valid),
      .rsp_run_thread   (rsp_run_thread),
      .rsp_top_priority (rsp_top_priority),
      .rsp_ready_bits   (rsp_ready_bits),
      .rsp_error_code   (rsp_error_code)
   );

endmodule : priority_ready_queue_scheduler
`default_nettype wire
